FILE: rtl/core/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_FREE     = 2'd1;
    localparam logic [1:0] CMD_COALESCE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FAIL      = 2'd1;
    localparam logic [1:0] ST_NOTHING   = 2'd2;

    localparam int unsigned WORD_W      = 16;
    localparam logic [15:0] MAGIC_WORD  = 16'd515;
    localparam logic [15:0] NIL_LINK    = 16'hFFFF;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] req_size;
        logic [6:0] block_address;
    } ffha_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] payload_address;
        logic [7:0] words_saved;
    } ffha_out_t;

endpackage

FILE: rtl/core/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: command sequencer around the heap RAM.
//
// First-fit allocator over a HEAP_WORDS x 16 store; each chunk has a size word and a
// link word. One command is worked at a time by a sequencer that reads and writes the
// heap RAM one word per cycle (registered read). Allocate walks the free list past each
// chunk that is too small, then takes an exact fit or splits the chunk; the first
// allocate formats the heap before it. Free walks the chunk tiling and then the free
// list. Coalesce walks the list nodes. A rejected command goes straight to the result.
// The list walks through the single RAM read port set the rate. A new command is taken
// while the previous result still waits on the output register.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = 128
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffha_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ffha_out_t m_data
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = $clog2(HEAP_WORDS + 1);
    localparam int GW = $clog2(2 * HEAP_WORDS + 1);
    localparam logic [17:0] HEAP18 = 18'(HEAP_WORDS);
    localparam logic [SW-1:0] STEP_MAX = SW'(HEAP_WORDS);
    localparam logic [GW-1:0] GUARD_INIT = GW'(2 * HEAP_WORDS);

    typedef enum logic [4:0] {
        IDLE, FMT0, FMT1,
        A_CHK, A_SZ, A_LNK, A_NXTD, A_WREM, A_WRL, A_WCUR, A_LINK, A_WMAG,
        T_CHK, T_RD, L_CHK, L_RD, F_WR,
        C_CHK, C_N, C_SC, C_SN, C_NL, C_M2, C_BL,
        FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     head_reg, head_next;
    logic            ready_reg, ready_next;
    logic [15:0]     cur_reg, cur_next;
    logic [15:0]     prev_reg, prev_next;
    logic [7:0]      req_reg, req_next;
    logic [6:0]      h_reg, h_next;
    logic [17:0]     p_reg, p_next;
    logic [15:0]     s_reg, s_next;
    logic [15:0]     nxt_reg, nxt_next;
    logic [17:0]     repl_reg, repl_next;
    logic [15:0]     n_reg, n_next;
    logic [15:0]     sc_reg, sc_next;
    logic [15:0]     nl_reg, nl_next;
    logic [SW-1:0]   steps_reg, steps_next;
    logic [GW-1:0]   guard_reg, guard_next;
    logic [15:0]     count_reg, count_next;
    ffha_out_t       res_reg, res_next;
    ffha_out_t       m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;

    logic            wr_req;
    logic [17:0]     wr_addr;
    logic [15:0]     wr_data;
    logic [17:0]     rd_addr;
    logic            mem_we;
    logic [15:0]     mem_rdata;

    function automatic logic hdr_ok(input logic [15:0] a);
        return (18'(a) + 18'd1) < HEAP18;
    endfunction

    ffha_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_heap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wr_addr[AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Drop writes that fall outside the store
    assign mem_we  = wr_req && (wr_addr < HEAP18);
    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequence the commands
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        ready_next   = ready_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        req_next     = req_reg;
        h_next       = h_reg;
        p_next       = p_reg;
        s_next       = s_reg;
        nxt_next     = nxt_reg;
        repl_next    = repl_reg;
        n_next       = n_reg;
        sc_next      = sc_reg;
        nl_next      = nl_reg;
        steps_next   = steps_reg;
        guard_next   = guard_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_req       = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_addr      = '0;

        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    req_next   = s_data.req_size;
                    res_next   = '0;
                    prev_next  = NIL_LINK;
                    cur_next   = head_reg;
                    steps_next = '0;
                    case (s_data.command)
                        CMD_ALLOC: begin
                            if (!ready_reg) begin
                                state_next = FMT0;
                            end else if (s_data.req_size == 8'd0) begin
                                res_next.status = ST_FAIL;
                                state_next      = FIN;
                            end else begin
                                state_next = A_CHK;
                            end
                        end
                        CMD_FREE: begin
                            if (!ready_reg || s_data.block_address < 7'd2) begin
                                res_next.status = ST_FAIL;
                                state_next      = FIN;
                            end else begin
                                h_next     = s_data.block_address - 7'd2;
                                p_next     = '0;
                                state_next = T_CHK;
                            end
                        end
                        CMD_COALESCE: begin
                            if (!ready_reg) begin
                                res_next.status = ST_NOTHING;
                                state_next      = FIN;
                            end else begin
                                guard_next = GUARD_INIT;
                                count_next = '0;
                                state_next = C_CHK;
                            end
                        end
                        default: begin
                            res_next.status = ST_FAIL;
                            state_next      = FIN;
                        end
                    endcase
                end
            end
            // Format the heap as one free chunk
            FMT0: begin
                wr_req     = 1'b1;
                wr_addr    = 18'd0;
                wr_data    = 16'(HEAP_WORDS - 2);
                state_next = FMT1;
            end
            FMT1: begin
                wr_req     = 1'b1;
                wr_addr    = 18'd1;
                wr_data    = NIL_LINK;
                head_next  = '0;
                ready_next = 1'b1;
                cur_next   = '0;
                if (req_reg == 8'd0) begin
                    res_next.status = ST_FAIL;
                    state_next      = FIN;
                end else begin
                    state_next = A_CHK;
                end
            end
            // Walk the free list for the first fit
            A_CHK: begin
                rd_addr = 18'(cur_reg);
                if (!hdr_ok(cur_reg)) begin
                    res_next.status = ST_FAIL;
                    state_next      = FIN;
                end else begin
                    state_next = A_SZ;
                end
            end
            A_SZ: begin
                s_next  = mem_rdata;
                rd_addr = 18'(cur_reg) + 18'd1;
                if (mem_rdata >= 16'(req_reg)) begin
                    state_next = A_NXTD;
                end else if (steps_reg >= STEP_MAX) begin
                    res_next.status = ST_FAIL;
                    state_next      = FIN;
                end else begin
                    prev_next  = cur_reg;
                    state_next = A_LNK;
                end
            end
            A_LNK: begin
                cur_next   = mem_rdata;
                steps_next = steps_reg + SW'(1);
                state_next = A_CHK;
            end
            // Split or take the whole chunk
            A_NXTD: begin
                nxt_next = mem_rdata;
                if ((s_reg - 16'(req_reg)) >= 16'd2) begin
                    repl_next  = 18'(cur_reg) + 18'd2 + 18'(req_reg);
                    state_next = A_WREM;
                end else begin
                    repl_next  = 18'(mem_rdata);
                    state_next = A_LINK;
                end
            end
            A_WREM: begin
                wr_req     = 1'b1;
                wr_addr    = repl_reg;
                wr_data    = s_reg - 16'(req_reg) - 16'd2;
                state_next = A_WRL;
            end
            A_WRL: begin
                wr_req     = 1'b1;
                wr_addr    = repl_reg + 18'd1;
                wr_data    = nxt_reg;
                state_next = A_WCUR;
            end
            A_WCUR: begin
                wr_req     = 1'b1;
                wr_addr    = 18'(cur_reg);
                wr_data    = 16'(req_reg);
                state_next = A_LINK;
            end
            A_LINK: begin
                if (prev_reg == NIL_LINK) begin
                    head_next = repl_reg[15:0];
                end else begin
                    wr_req  = 1'b1;
                    wr_addr = 18'(prev_reg) + 18'd1;
                    wr_data = repl_reg[15:0];
                end
                state_next = A_WMAG;
            end
            A_WMAG: begin
                wr_req                   = 1'b1;
                wr_addr                  = 18'(cur_reg) + 18'd1;
                wr_data                  = MAGIC_WORD;
                res_next.status          = ST_DONE;
                res_next.payload_address = 7'(cur_reg + 16'd2);
                state_next               = FIN;
            end
            // Check the address lies on the chunk tiling
            T_CHK: begin
                rd_addr = p_reg;
                if ((p_reg + 18'd1) < HEAP18 && p_reg < 18'(h_reg)) begin
                    state_next = T_RD;
                end else if (p_reg == 18'(h_reg) && (p_reg + 18'd1) < HEAP18) begin
                    state_next = L_CHK;
                end else begin
                    res_next.status = ST_FAIL;
                    state_next      = FIN;
                end
            end
            T_RD: begin
                p_next     = p_reg + 18'(mem_rdata) + 18'd2;
                state_next = T_CHK;
            end
            // Reject a chunk that is already free
            L_CHK: begin
                rd_addr = 18'(cur_reg) + 18'd1;
                if (hdr_ok(cur_reg) && steps_reg < STEP_MAX) begin
                    if (cur_reg == 16'(h_reg)) begin
                        res_next.status = ST_FAIL;
                        state_next      = FIN;
                    end else begin
                        state_next = L_RD;
                    end
                end else begin
                    state_next = F_WR;
                end
            end
            L_RD: begin
                cur_next   = mem_rdata;
                steps_next = steps_reg + SW'(1);
                state_next = L_CHK;
            end
            F_WR: begin
                wr_req          = 1'b1;
                wr_addr         = 18'(h_reg) + 18'd1;
                wr_data         = head_reg;
                head_next       = 16'(h_reg);
                res_next.status = ST_DONE;
                state_next      = FIN;
            end
            // Merge list neighbors that touch in memory
            C_CHK: begin
                rd_addr = 18'(cur_reg) + 18'd1;
                if (hdr_ok(cur_reg) && guard_reg != '0) begin
                    guard_next = guard_reg - GW'(1);
                    state_next = C_N;
                end else begin
                    res_next.words_saved = count_reg[7:0];
                    res_next.status      = (count_reg == '0) ? ST_NOTHING : ST_DONE;
                    state_next           = FIN;
                end
            end
            C_N: begin
                n_next  = mem_rdata;
                rd_addr = 18'(cur_reg);
                if (!hdr_ok(mem_rdata)) begin
                    res_next.words_saved = count_reg[7:0];
                    res_next.status      = (count_reg == '0) ? ST_NOTHING : ST_DONE;
                    state_next           = FIN;
                end else begin
                    state_next = C_SC;
                end
            end
            C_SC: begin
                sc_next    = mem_rdata;
                rd_addr    = 18'(n_reg);
                state_next = C_SN;
            end
            C_SN: begin
                rd_addr = 18'(n_reg) + 18'd1;
                if (18'(n_reg) == 18'(cur_reg) + 18'd2 + 18'(sc_reg)) begin
                    s_next     = mem_rdata;
                    state_next = C_NL;
                end else if (18'(cur_reg) == 18'(n_reg) + 18'd2 + 18'(mem_rdata)) begin
                    wr_req     = 1'b1;
                    wr_addr    = 18'(n_reg);
                    wr_data    = mem_rdata + sc_reg + 16'd2;
                    cur_next   = n_reg;
                    count_next = count_reg + 16'd2;
                    if (prev_reg == NIL_LINK) begin
                        head_next  = n_reg;
                        state_next = C_CHK;
                    end else begin
                        state_next = C_BL;
                    end
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = n_reg;
                    state_next = C_CHK;
                end
            end
            C_NL: begin
                nl_next    = mem_rdata;
                wr_req     = 1'b1;
                wr_addr    = 18'(cur_reg);
                wr_data    = sc_reg + s_reg + 16'd2;
                state_next = C_M2;
            end
            C_M2: begin
                wr_req     = 1'b1;
                wr_addr    = 18'(cur_reg) + 18'd1;
                wr_data    = nl_reg;
                count_next = count_reg + 16'd2;
                state_next = C_CHK;
            end
            C_BL: begin
                wr_req     = 1'b1;
                wr_addr    = 18'(prev_reg) + 18'd1;
                wr_data    = n_reg;
                state_next = C_CHK;
            end
            // Hand the result word to the output register
            FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            head_reg    <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        req_reg    <= req_next;
        h_reg      <= h_next;
        p_reg      <= p_next;
        s_reg      <= s_next;
        nxt_reg    <= nxt_next;
        repl_reg   <= repl_next;
        n_reg      <= n_next;
        sc_reg     <= sc_next;
        nl_reg     <= nl_next;
        steps_reg  <= steps_next;
        guard_reg  <= guard_next;
        count_reg  <= count_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: sim/first_fit_heap_allocator_core_tb.sv
// Testbench for the first-fit heap allocator core: random and directed commands.
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    localparam int HEAP_WORDS = 128;
    localparam int IDLE_LIMIT = 20000;

    // Heap predictor and queue of predicted result words
    class heap_scoreboard;
        logic [15:0] heap [HEAP_WORDS];
        logic [15:0] head;
        bit          formatted;
        ffha_out_t   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < HEAP_WORDS; i++) heap[i] = '0;
            head = '0;
            formatted = 0;
            errors = 0;
        endfunction

        function bit hdr_ok(int unsigned h);
            return h + 1 < HEAP_WORDS;
        endfunction

        function int unsigned rd(int unsigned a);
            return a < HEAP_WORDS ? heap[a] : 0;
        endfunction

        function void wr(int unsigned a, int unsigned v);
            if (a < HEAP_WORDS) heap[a] = v[15:0];
        endfunction

        function void relink(int unsigned prev, int unsigned v);
            if (prev == NIL_LINK) head = v[15:0];
            else wr(prev + 1, v);
        endfunction

        function logic [1:0] alloc(int unsigned req, output logic [6:0] pay);
            int unsigned prev, cur, s, nxt, repl, steps;
            prev = NIL_LINK;
            steps = 0;
            pay = '0;
            if (!formatted) begin
                heap[0] = 16'(HEAP_WORDS - 2);
                heap[1] = NIL_LINK;
                head = '0;
                formatted = 1;
            end
            if (req == 0) return ST_FAIL;
            cur = head;
            while (hdr_ok(cur) && steps < HEAP_WORDS) begin
                if (rd(cur) >= req) break;
                prev = cur;
                cur = rd(cur + 1);
                steps++;
            end
            if (!hdr_ok(cur) || rd(cur) < req) return ST_FAIL;
            s = rd(cur);
            nxt = rd(cur + 1);
            if (s - req >= 2) begin
                repl = cur + 2 + req;
                wr(repl, s - req - 2);
                wr(repl + 1, nxt);
                wr(cur, req);
            end else begin
                repl = nxt;
            end
            relink(prev, repl);
            wr(cur + 1, MAGIC_WORD);
            pay = 7'(cur + 2);
            return ST_DONE;
        endfunction

        function logic [1:0] release_chunk(int unsigned addr);
            int unsigned h, p, cur, steps;
            if (!formatted || addr < 2) return ST_FAIL;
            h = addr - 2;
            p = 0;
            while (hdr_ok(p) && p < h) p += rd(p) + 2;
            if (!(p == h && hdr_ok(p))) return ST_FAIL;
            cur = head;
            steps = 0;
            while (hdr_ok(cur) && steps < HEAP_WORDS) begin
                if (cur == h) return ST_FAIL;
                cur = rd(cur + 1);
                steps++;
            end
            wr(h + 1, head);
            head = h[15:0];
            return ST_DONE;
        endfunction

        function logic [1:0] merge(output logic [7:0] saved);
            int unsigned prev, cur, n, sc, sn, guard, count;
            prev = NIL_LINK;
            guard = 2 * HEAP_WORDS;
            count = 0;
            saved = '0;
            if (!formatted) return ST_NOTHING;
            cur = head;
            while (hdr_ok(cur) && guard > 0) begin
                guard--;
                n = rd(cur + 1);
                if (!hdr_ok(n)) break;
                sc = rd(cur);
                sn = rd(n);
                if (n == cur + 2 + sc) begin
                    wr(cur, sc + sn + 2);
                    wr(cur + 1, rd(n + 1));
                    count += 2;
                end else if (cur == n + 2 + sn) begin
                    wr(n, sn + sc + 2);
                    relink(prev, n);
                    cur = n;
                    count += 2;
                end else begin
                    prev = cur;
                    cur = n;
                end
            end
            saved = count[7:0];
            return count == 0 ? ST_NOTHING : ST_DONE;
        endfunction

        // Predict the result of one accepted command word
        function void note_command(ffha_in_t w);
            ffha_out_t r;
            r = '0;
            case (w.command)
                CMD_ALLOC:    r.status = alloc(w.req_size, r.payload_address);
                CMD_FREE:     r.status = release_chunk(w.block_address);
                CMD_COALESCE: r.status = merge(r.words_saved);
                default:      r.status = ST_FAIL;
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endfunction

        // Compare one result word with the oldest prediction
        function void check_result(ffha_out_t got);
            ffha_out_t exp_r;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                report($sformatf("status %0d, want %0d", got.status, exp_r.status));
            if (got.payload_address !== exp_r.payload_address)
                report($sformatf("payload_address %0d, want %0d",
                                 got.payload_address, exp_r.payload_address));
            if (got.words_saved !== exp_r.words_saved)
                report($sformatf("words_saved %0d, want %0d",
                                 got.words_saved, exp_r.words_saved));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ffha_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    ffha_out_t m_data;

    heap_scoreboard sb;
    bit  calm;
    bit  timed_out;
    int  idle_cycles;
    logic [6:0] live [$];

    first_fit_heap_allocator_core #(.HEAP_WORDS(HEAP_WORDS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Send one command word, with a random idle gap first; valid drops only while idling
    task automatic send(logic [1:0] cmd, logic [7:0] req, logic [6:0] addr);
        ffha_in_t w;
        w.command = cmd;
        w.req_size = req;
        w.block_address = addr;
        while (!calm && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(w);
    endtask

    // Drop valid and hold off until every predicted result has come
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
    endtask

    // Track live chunks from result words so frees hit real payloads
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sb.pending.size() != 0 && sb.pending[0].status == ST_DONE &&
                sb.pending[0].payload_address != 0)
                live.insert(live.size(), sb.pending[0].payload_address);
            sb.check_result(m_data);
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(99) >= 28);
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int k, pick;
        sb = new();
        calm = 0;
        timed_out = 0;
        idle_cycles = 0;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unformatted heap, zero size, oversize, splits, bad frees
        send(CMD_FREE, 8'd0, 7'd2);
        send(CMD_COALESCE, 8'd0, 7'd0);
        send(CMD_ALLOC, 8'd0, 7'd0);
        send(CMD_ALLOC, 8'd128, 7'd0);
        send(CMD_ALLOC, 8'd255, 7'd0);
        send(CMD_ALLOC, 8'd4, 7'd0);
        send(CMD_ALLOC, 8'd5, 7'd0);
        send(CMD_ALLOC, 8'd1, 7'd0);
        send(CMD_FREE, 8'd0, 7'd0);
        send(CMD_FREE, 8'd0, 7'd1);
        send(CMD_FREE, 8'd0, 7'd3);
        send(CMD_FREE, 8'd0, 7'd127);
        send(CMD_FREE, 8'd0, 7'd2);
        send(CMD_FREE, 8'd0, 7'd2);
        send(CMD_FREE, 8'd0, 7'd8);
        send(CMD_COALESCE, 8'd0, 7'd0);
        send(CMD_ALLOC, 8'd9, 7'd0);
        send(CMD_ALLOC, 8'd8, 7'd0);
        send(2'd3, 8'hFF, 7'h7F);
        send(CMD_ALLOC, 8'd104, 7'd0);
        send(CMD_ALLOC, 8'd1, 7'd0);
        send(CMD_FREE, 8'd0, 7'd17);
        send(CMD_COALESCE, 8'd0, 7'd0);

        // Pause until everything is back, then run random traffic
        drain();
        for (k = 0; k < 700; k++) begin
            calm = (k >= 300 && k < 400);
            pick = $urandom_range(99);
            if (pick < 45)
                send(CMD_ALLOC, ($urandom_range(9) == 0) ? 8'($urandom) :
                     8'($urandom_range(1, 20)), 7'd0);
            else if (pick < 80 && live.size() != 0) begin
                drain();
                pick = $urandom_range(live.size() - 1);
                send(CMD_FREE, 8'($urandom), live[pick]);
                live.delete(pick);
            end else if (pick < 88)
                send(CMD_FREE, 8'($urandom), 7'($urandom));
            else if (pick < 97)
                send(CMD_COALESCE, 8'($urandom), 7'($urandom));
            else
                send(2'd3, 8'($urandom), 7'($urandom));
        end

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/first_fit_heap_allocator_core.sv
sim/first_fit_heap_allocator_core_tb.sv
